// ----- rtl/core/ppi_pkg.sv -----
// ----------------------------------------------------------------------------
// ppi_pkg
// Shared types, constants and the arctangent table for the pose integrator.
// ----------------------------------------------------------------------------
package ppi_pkg;

    // input word codes
    localparam logic [1:0] ACT_CMD  = 2'd0;
    localparam logic [1:0] ACT_TELE = 2'd1;
    localparam logic [1:0] ACT_TICK = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_SCALE   = 2'd0;
    localparam logic [1:0] REG_SPAN_X  = 2'd1;
    localparam logic [1:0] REG_SPAN_Y  = 2'd2;
    localparam logic [1:0] REG_TIMEOUT = 2'd3;

    // configuration reset values
    localparam logic [23:0] SCALE_RST   = 24'd65536;
    localparam logic [31:0] SPAN_RST    = 32'd32768000;
    localparam logic [31:0] TIMEOUT_RST = 32'd65536;

    // default rotation step count
    localparam int CORDIC_STEPS_DEF = 16;

    // angle constants
    localparam logic [31:0]        TWO_PI_Q16  = 32'd411775;
    localparam logic signed [32:0] PI_Q28      = 33'sd843314857;
    localparam logic signed [32:0] TWO_PI_Q28  = 33'sd1686629713;
    localparam logic signed [32:0] HALF_PI_Q28 = 33'sd421657428;
    localparam logic signed [31:0] GAIN_Q28    = 32'sd163008219;

    // input word
    typedef struct packed {
        logic [1:0]         action;
        logic signed [23:0] linear_speed;
        logic signed [23:0] turn_rate;
        logic signed [23:0] climb_speed;
        logic [31:0]        new_x;
        logic [31:0]        new_y;
        logic [31:0]        new_altitude;
        logic signed [19:0] new_heading;
        logic [15:0]        step_time;
    } ppi_in_t;

    // result word
    typedef struct packed {
        logic [31:0]        pose_x;
        logic [31:0]        pose_y;
        logic [31:0]        pose_altitude;
        logic signed [19:0] pose_heading;
        logic               timed_out;
    } ppi_out_t;

    // arctangent of 2^-i in Q28
    function automatic logic signed [32:0] atan_q28(input logic [4:0] idx);
        logic signed [32:0] v;
        case (idx)
            5'd0:  v = 33'sd210828714;
            5'd1:  v = 33'sd124459457;
            5'd2:  v = 33'sd65760959;
            5'd3:  v = 33'sd33381290;
            5'd4:  v = 33'sd16755422;
            5'd5:  v = 33'sd8385879;
            5'd6:  v = 33'sd4193963;
            5'd7:  v = 33'sd2097109;
            5'd8:  v = 33'sd1048571;
            5'd9:  v = 33'sd524287;
            5'd10: v = 33'sd262144;
            5'd11: v = 33'sd131072;
            5'd12: v = 33'sd65536;
            5'd13: v = 33'sd32768;
            5'd14: v = 33'sd16384;
            5'd15: v = 33'sd8192;
            5'd16: v = 33'sd4096;
            5'd17: v = 33'sd2048;
            5'd18: v = 33'sd1024;
            5'd19: v = 33'sd512;
            5'd20: v = 33'sd256;
            5'd21: v = 33'sd128;
            5'd22: v = 33'sd64;
            5'd23: v = 33'sd32;
            default: v = 33'sd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/planar_pose_integrator_core.sv -----
// ----------------------------------------------------------------------------
// planar_pose_integrator_core
// Unicycle odometry integrator with altitude, bit-serial arithmetic.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one input word: a velocity command, a
//   teleport or a time tick. in_stall is high while a tick is being worked.
//   Commands and teleports produce no result and leave the block idle.
//   A tick produces one result word on out_valid/out_stall/out_data.
//   A tick runs through one shared radix-2 shift-add multiplier (seven
//   products), one restoring remainder unit (three uses) and the CORDIC
//   rotator (one step per cycle).
//   The next word is taken while a result still waits in the output register;
//   a finished tick holds in its last state until that register is free.
//   cfg_write/cfg_index/cfg_data write a register at the clock edge; write
//   only while the block is idle.
//   Reset clears the pose, speeds and idle timer, and loads the register
//   defaults; no result is pending after reset.
// ----------------------------------------------------------------------------
module planar_pose_integrator_core #(
    parameter int CORDIC_STEPS = ppi_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  ppi_pkg::ppi_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output ppi_pkg::ppi_out_t out_data,
    input  logic              cfg_write,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ppi_pkg::*;

    localparam int CIW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // sequencer codes
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_TSTART = 5'd1;
    localparam logic [4:0] S_MUL   = 5'd2;
    localparam logic [4:0] S_DIV   = 5'd3;
    localparam logic [4:0] S_HSUM  = 5'd4;
    localparam logic [4:0] S_HMOD  = 5'd5;
    localparam logic [4:0] S_RED1  = 5'd6;
    localparam logic [4:0] S_RED2  = 5'd7;
    localparam logic [4:0] S_CORD  = 5'd8;
    localparam logic [4:0] S_CFIN  = 5'd9;
    localparam logic [4:0] S_ADONE = 5'd10;
    localparam logic [4:0] S_BDONE = 5'd11;
    localparam logic [4:0] S_XDONE = 5'd12;
    localparam logic [4:0] S_YDONE = 5'd13;
    localparam logic [4:0] S_Z1    = 5'd14;
    localparam logic [4:0] S_Z2    = 5'd15;
    localparam logic [4:0] S_XWRAP = 5'd16;
    localparam logic [4:0] S_YWRAP = 5'd17;
    localparam logic [4:0] S_EMIT  = 5'd18;

    // control and state
    logic [4:0]         state_reg, state_next;
    logic [4:0]         ret_reg, ret_next;
    logic [23:0]        scale_reg, scale_next;
    logic [31:0]        span_x_reg, span_x_next;
    logic [31:0]        span_y_reg, span_y_next;
    logic [31:0]        timeout_reg, timeout_next;
    logic [31:0]        pos_x_reg, pos_x_next;
    logic [31:0]        pos_y_reg, pos_y_next;
    logic [31:0]        alt_reg, alt_next;
    logic signed [19:0] heading_reg, heading_next;
    logic signed [23:0] fwd_reg, fwd_next;
    logic signed [23:0] ang_reg, ang_next;
    logic signed [23:0] vert_reg, vert_next;
    logic [31:0]        idle_reg, idle_next;
    logic               to_reg, to_next;
    logic [15:0]        dt_reg, dt_next;

    // multiplier
    logic signed [58:0] acc_reg, acc_next;
    logic signed [58:0] ash_reg, ash_next;
    logic [24:0]        bsh_reg, bsh_next;
    logic [4:0]         mcnt_reg, mcnt_next;

    // remainder unit
    logic [33:0]        dq_reg, dq_next;
    logic [31:0]        rem_reg, rem_next;
    logic [31:0]        dv_reg, dv_next;
    logic [5:0]         dcnt_reg, dcnt_next;
    logic               dneg_reg, dneg_next;

    // rotator
    logic signed [32:0] z_reg, z_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] y_reg, y_next;
    logic [CIW-1:0]     ci_reg, ci_next;
    logic               neg_reg, neg_next;
    logic signed [17:0] c_reg, c_next;
    logic signed [17:0] s_reg, s_next;

    // tick intermediates
    logic signed [32:0] b_reg, b_next;
    logic signed [33:0] nx_reg, nx_next;
    logic signed [33:0] ny_reg, ny_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    ppi_out_t           out_reg, out_next;

    // combinational helpers
    logic               mul_go;
    logic signed [33:0] mul_a;
    logic [24:0]        mul_b;
    logic [4:0]         mul_n;
    logic               div_go;
    logic [33:0]        div_mag;
    logic [31:0]        div_dv;
    logic               div_neg;
    logic [4:0]         go_ret;
    logic signed [58:0] acc_rnd;
    logic signed [42:0] rnd;
    logic [32:0]        idle_sum;
    logic [31:0]        idle_new;
    logic signed [24:0] hsum;
    logic signed [19:0] hval;
    logic [32:0]        dtrial;
    logic signed [31:0] xsh;
    logic signed [31:0] ysh;
    logic signed [32:0] atan_v;
    logic signed [31:0] xr;
    logic signed [31:0] yr;
    logic signed [33:0] nz;
    logic [31:0]        wrapped;
    logic               accept;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // rounded product, floor(p / 2^16 + 1/2)
    assign acc_rnd = acc_reg + 59'sd32768;
    assign rnd     = acc_rnd[58:16];

    // rotator shifts and angle
    assign xsh    = x_reg >>> ci_reg;
    assign ysh    = y_reg >>> ci_reg;
    assign atan_v = atan_q28(5'(ci_reg));

    // remainder trial subtract
    assign dtrial = {rem_reg, dq_reg[33]};

    // wrap result from the remainder unit
    always_comb
    begin
        if (dneg_reg && (rem_reg != 32'd0))
        begin
            wrapped = dv_reg - rem_reg;
        end
        else
        begin
            wrapped = rem_reg;
        end
    end

    // sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        scale_next     = scale_reg;
        span_x_next    = span_x_reg;
        span_y_next    = span_y_reg;
        timeout_next   = timeout_reg;
        pos_x_next     = pos_x_reg;
        pos_y_next     = pos_y_reg;
        alt_next       = alt_reg;
        heading_next   = heading_reg;
        fwd_next       = fwd_reg;
        ang_next       = ang_reg;
        vert_next      = vert_reg;
        idle_next      = idle_reg;
        to_next        = to_reg;
        dt_next        = dt_reg;
        acc_next       = acc_reg;
        ash_next       = ash_reg;
        bsh_next       = bsh_reg;
        mcnt_next      = mcnt_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        dv_next        = dv_reg;
        dcnt_next      = dcnt_reg;
        dneg_next      = dneg_reg;
        z_next         = z_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        ci_next        = ci_reg;
        neg_next       = neg_reg;
        c_next         = c_reg;
        s_next         = s_reg;
        b_next         = b_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;

        mul_go  = 1'b0;
        mul_a   = '0;
        mul_b   = '0;
        mul_n   = '0;
        div_go  = 1'b0;
        div_mag = '0;
        div_dv  = '0;
        div_neg = 1'b0;
        go_ret  = S_IDLE;

        idle_sum = {1'b0, idle_reg} + {17'd0, in_data.step_time};
        idle_new = idle_sum[32] ? 32'hFFFF_FFFF : idle_sum[31:0];
        hsum     = 25'(heading_reg) + rnd[24:0];
        hval     = $signed({1'b0, rem_reg[18:0]});
        xr       = (x_reg + 32'sd2048) >>> 12;
        yr       = (y_reg + 32'sd2048) >>> 12;
        nz       = $signed({2'b00, alt_reg}) + rnd[33:0];

        // register writes
        if (cfg_write)
        begin
            case (cfg_index)
                REG_SCALE:   scale_next   = cfg_data[23:0];
                REG_SPAN_X:  span_x_next  = cfg_data;
                REG_SPAN_Y:  span_y_next  = cfg_data;
                REG_TIMEOUT: timeout_next = cfg_data;
                default:     scale_next   = scale_reg;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.action)
                        ACT_CMD:
                        begin
                            fwd_next  = in_data.linear_speed;
                            ang_next  = in_data.turn_rate;
                            vert_next = in_data.climb_speed;
                            idle_next = 32'd0;
                        end
                        ACT_TELE:
                        begin
                            pos_x_next   = in_data.new_x;
                            pos_y_next   = in_data.new_y;
                            alt_next     = in_data.new_altitude;
                            heading_next = in_data.new_heading;
                            fwd_next     = '0;
                            ang_next     = '0;
                            vert_next    = '0;
                        end
                        ACT_TICK:
                        begin
                            idle_next = idle_new;
                            dt_next   = in_data.step_time;
                            to_next   = (idle_new > timeout_reg);
                            if (idle_new > timeout_reg)
                            begin
                                fwd_next  = '0;
                                ang_next  = '0;
                                vert_next = '0;
                            end
                            state_next = S_TSTART;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // turn * dt
            S_TSTART:
            begin
                mul_go = 1'b1;
                mul_a  = 34'(ang_reg);
                mul_b  = {9'd0, dt_reg};
                mul_n  = 5'd16;
                go_ret = S_HSUM;
            end

            // one multiplier bit per cycle, the top bit weighs negative
            S_MUL:
            begin
                if (bsh_reg[0])
                begin
                    if (mcnt_reg == 5'd0)
                    begin
                        acc_next = acc_reg - ash_reg;
                    end
                    else
                    begin
                        acc_next = acc_reg + ash_reg;
                    end
                end
                ash_next  = ash_reg <<< 1;
                bsh_next  = bsh_reg >> 1;
                mcnt_next = mcnt_reg - 5'd1;
                if (mcnt_reg == 5'd0)
                begin
                    state_next = ret_reg;
                end
            end

            // one quotient bit per cycle, remainder kept
            S_DIV:
            begin
                if (dtrial >= {1'b0, dv_reg})
                begin
                    rem_next = 32'(dtrial - {1'b0, dv_reg});
                end
                else
                begin
                    rem_next = dtrial[31:0];
                end
                dq_next   = dq_reg << 1;
                dcnt_next = dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd0)
                begin
                    state_next = ret_reg;
                end
            end

            // heading sum, then reduce by two pi with the sign kept
            S_HSUM:
            begin
                div_go  = 1'b1;
                div_neg = hsum[24];
                div_mag = hsum[24] ? 34'(-hsum) : 34'(hsum);
                div_dv  = TWO_PI_Q16;
                go_ret  = S_HMOD;
            end

            S_HMOD:
            begin
                if (dneg_reg)
                begin
                    heading_next = -hval;
                    z_next       = 33'(-hval) <<< 12;
                end
                else
                begin
                    heading_next = hval;
                    z_next       = 33'(hval) <<< 12;
                end
                state_next = S_RED1;
            end

            // angle into [-pi, pi]
            S_RED1:
            begin
                if (z_reg > PI_Q28)
                begin
                    if ((z_reg - TWO_PI_Q28) < -PI_Q28)
                    begin
                        z_next = z_reg;
                    end
                    else
                    begin
                        z_next = z_reg - TWO_PI_Q28;
                    end
                end
                else if (z_reg < -PI_Q28)
                begin
                    z_next = z_reg + TWO_PI_Q28;
                end
                state_next = S_RED2;
            end

            // fold into [-pi/2, pi/2]
            S_RED2:
            begin
                neg_next = 1'b0;
                if (z_reg > HALF_PI_Q28)
                begin
                    z_next   = z_reg - PI_Q28;
                    neg_next = 1'b1;
                end
                else if (z_reg < -HALF_PI_Q28)
                begin
                    z_next   = z_reg + PI_Q28;
                    neg_next = 1'b1;
                end
                x_next     = GAIN_Q28;
                y_next     = 32'sd0;
                ci_next    = '0;
                state_next = S_CORD;
            end

            // one rotation per cycle
            S_CORD:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - ysh;
                    y_next = y_reg + xsh;
                    z_next = z_reg - atan_v;
                end
                else
                begin
                    x_next = x_reg + ysh;
                    y_next = y_reg - xsh;
                    z_next = z_reg + atan_v;
                end
                ci_next = ci_reg + CIW'(1);
                if (ci_reg == CIW'(CORDIC_STEPS - 1))
                begin
                    state_next = S_CFIN;
                end
            end

            // cos and sin in Q16, then forward * dt
            S_CFIN:
            begin
                c_next = neg_reg ? -xr[17:0] : xr[17:0];
                s_next = neg_reg ? -yr[17:0] : yr[17:0];
                mul_go = 1'b1;
                mul_a  = 34'(fwd_reg);
                mul_b  = {9'd0, dt_reg};
                mul_n  = 5'd16;
                go_ret = S_ADONE;
            end

            // scale * a
            S_ADONE:
            begin
                mul_go = 1'b1;
                mul_a  = 34'($signed(rnd[23:0]));
                mul_b  = {1'b0, scale_reg};
                mul_n  = 5'd24;
                go_ret = S_BDONE;
            end

            // b * cos
            S_BDONE:
            begin
                b_next = rnd[32:0];
                mul_go = 1'b1;
                mul_a  = 34'($signed(rnd[32:0]));
                mul_b  = 25'(c_reg);
                mul_n  = 5'd17;
                go_ret = S_XDONE;
            end

            // b * sin
            S_XDONE:
            begin
                nx_next = $signed({2'b00, pos_x_reg}) + rnd[33:0];
                mul_go  = 1'b1;
                mul_a   = 34'(b_reg);
                mul_b   = 25'(s_reg);
                mul_n   = 5'd17;
                go_ret  = S_YDONE;
            end

            // climb * dt
            S_YDONE:
            begin
                ny_next = $signed({2'b00, pos_y_reg}) - rnd[33:0];
                mul_go  = 1'b1;
                mul_a   = 34'(vert_reg);
                mul_b   = {9'd0, dt_reg};
                mul_n   = 5'd16;
                go_ret  = S_Z1;
            end

            // scale * climb step
            S_Z1:
            begin
                mul_go = 1'b1;
                mul_a  = 34'($signed(rnd[23:0]));
                mul_b  = {1'b0, scale_reg};
                mul_n  = 5'd24;
                go_ret = S_Z2;
            end

            // altitude kept only while positive, then wrap x
            S_Z2:
            begin
                if (nz > 34'sd0)
                begin
                    alt_next = (nz[33:32] != 2'b00) ? 32'hFFFF_FFFF : nz[31:0];
                end
                div_go  = 1'b1;
                div_neg = nx_reg[33];
                div_mag = nx_reg[33] ? 34'(-nx_reg) : 34'(nx_reg);
                div_dv  = span_x_reg;
                go_ret  = S_XWRAP;
            end

            // zero span wraps modulo 2^32
            S_XWRAP:
            begin
                pos_x_next = (dv_reg == 32'd0) ? nx_reg[31:0] : wrapped;
                div_go     = 1'b1;
                div_neg    = ny_reg[33];
                div_mag    = ny_reg[33] ? 34'(-ny_reg) : 34'(ny_reg);
                div_dv     = span_y_reg;
                go_ret     = S_YWRAP;
            end

            S_YWRAP:
            begin
                pos_y_next = (dv_reg == 32'd0) ? ny_reg[31:0] : wrapped;
                state_next = S_EMIT;
            end

            // wait for a free output register
            S_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_next.pose_x        = pos_x_reg;
                    out_next.pose_y        = pos_y_reg;
                    out_next.pose_altitude = alt_reg;
                    out_next.pose_heading  = heading_reg;
                    out_next.timed_out     = to_reg;
                    out_valid_next         = 1'b1;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // start the multiplier
        if (mul_go)
        begin
            acc_next   = '0;
            ash_next   = 59'(mul_a);
            bsh_next   = mul_b;
            mcnt_next  = mul_n;
            ret_next   = go_ret;
            state_next = S_MUL;
        end

        // start the remainder unit
        if (div_go)
        begin
            dq_next    = div_mag;
            rem_next   = 32'd0;
            dv_next    = div_dv;
            dneg_next  = div_neg;
            dcnt_next  = 6'd33;
            ret_next   = go_ret;
            state_next = S_DIV;
        end
    end

    // registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            scale_reg     <= SCALE_RST;
            span_x_reg    <= SPAN_RST;
            span_y_reg    <= SPAN_RST;
            timeout_reg   <= TIMEOUT_RST;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            alt_reg       <= '0;
            heading_reg   <= '0;
            fwd_reg       <= '0;
            ang_reg       <= '0;
            vert_reg      <= '0;
            idle_reg      <= '0;
            to_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            scale_reg     <= scale_next;
            span_x_reg    <= span_x_next;
            span_y_reg    <= span_y_next;
            timeout_reg   <= timeout_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            alt_reg       <= alt_next;
            heading_reg   <= heading_next;
            fwd_reg       <= fwd_next;
            ang_reg       <= ang_next;
            vert_reg      <= vert_next;
            idle_reg      <= idle_next;
            to_reg        <= to_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        dt_reg   <= dt_next;
        acc_reg  <= acc_next;
        ash_reg  <= ash_next;
        bsh_reg  <= bsh_next;
        mcnt_reg <= mcnt_next;
        dq_reg   <= dq_next;
        rem_reg  <= rem_next;
        dv_reg   <= dv_next;
        dcnt_reg <= dcnt_next;
        dneg_reg <= dneg_next;
        z_reg    <= z_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        ci_reg   <= ci_next;
        neg_reg  <= neg_next;
        c_reg    <= c_next;
        s_reg    <= s_next;
        b_reg    <= b_next;
        nx_reg   <= nx_next;
        ny_reg   <= ny_next;
        out_reg  <= out_next;
    end

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pose integrator core. Drives directed and
// random command, teleport and tick words through several register settings
// and idling mixes, predicts every tick pose and compares each result word.
// ----------------------------------------------------------------------------
import ppi_pkg::*;

// pose predictor and queue of expected tick results
class pose_scoreboard;
    bit [23:0]   scale;
    bit [31:0]   span_x;
    bit [31:0]   span_y;
    bit [31:0]   timeout;
    bit [31:0]   px;
    bit [31:0]   py;
    bit [31:0]   alt;
    int          heading;
    int          v_fwd;
    int          v_turn;
    int          v_climb;
    bit [31:0]   idle_acc;
    ppi_out_t    pending_poses[$];
    int          errors;
    longint      atan_tbl[24];

    function new();
        atan_tbl = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
                     4193963, 2097109, 1048571, 524287, 262144, 131072,
                     65536, 32768, 16384, 8192, 4096, 2048,
                     1024, 512, 256, 128, 64, 32};
        scale = SCALE_RST;
        span_x = SPAN_RST;
        span_y = SPAN_RST;
        timeout = TIMEOUT_RST;
        px = 0;
        py = 0;
        alt = 0;
        heading = 0;
        v_fwd = 0;
        v_turn = 0;
        v_climb = 0;
        idle_acc = 0;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, bit [31:0] val);
        case (idx)
            REG_SCALE:   scale = val[23:0];
            REG_SPAN_X:  span_x = val;
            REG_SPAN_Y:  span_y = val;
            REG_TIMEOUT: timeout = val;
            default:     scale = scale;
        endcase
    endfunction

    // round half up of v / 2^16
    function longint rnd16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function bit [31:0] wrap(longint p, bit [31:0] span);
        longint r;
        if (span == 0)
            return p[31:0];
        r = p % longint'(span);
        if (r < 0)
            r += longint'(span);
        return r[31:0];
    endfunction

    // advance the pose model by one accepted word
    function void note(ppi_in_t w);
        longint dt, h, c, s, a, b, nx, ny, nz, idle, z, x, y, tx;
        bit neg;
        bit to;
        ppi_out_t r;
        case (w.action)
            ACT_CMD:
            begin
                v_fwd = $signed(w.linear_speed);
                v_turn = $signed(w.turn_rate);
                v_climb = $signed(w.climb_speed);
                idle_acc = 0;
            end
            ACT_TELE:
            begin
                px = w.new_x;
                py = w.new_y;
                alt = w.new_altitude;
                heading = $signed(w.new_heading);
                v_fwd = 0;
                v_turn = 0;
                v_climb = 0;
            end
            ACT_TICK:
            begin
                dt = w.step_time;
                idle = longint'(idle_acc) + dt;
                idle_acc = (idle > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : idle[31:0];
                to = 0;
                if (idle_acc > timeout)
                begin
                    v_fwd = 0;
                    v_turn = 0;
                    v_climb = 0;
                    to = 1;
                end
                h = longint'(heading) + rnd16(longint'(v_turn) * dt);
                h = h % longint'(TWO_PI_Q16);
                heading = int'(h);
                // rotation for cos and sin
                z = h * 4096;
                x = GAIN_Q28;
                y = 0;
                neg = 0;
                if (z > PI_Q28) z -= TWO_PI_Q28;
                if (z < -PI_Q28) z += TWO_PI_Q28;
                if (z > HALF_PI_Q28)
                begin
                    z -= PI_Q28;
                    neg = 1;
                end
                else if (z < -HALF_PI_Q28)
                begin
                    z += PI_Q28;
                    neg = 1;
                end
                for (int i = 0; i < CORDIC_STEPS_DEF && i < 24; i++)
                begin
                    if (z >= 0)
                    begin
                        tx = x - (y >>> i);
                        y = y + (x >>> i);
                        z -= atan_tbl[i];
                    end
                    else
                    begin
                        tx = x + (y >>> i);
                        y = y - (x >>> i);
                        z += atan_tbl[i];
                    end
                    x = tx;
                end
                c = (x + 2048) >>> 12;
                s = (y + 2048) >>> 12;
                if (neg)
                begin
                    c = -c;
                    s = -s;
                end
                a = rnd16(longint'(v_fwd) * dt);
                b = rnd16(longint'(scale) * a);
                nx = longint'(px) + rnd16(b * c);
                ny = longint'(py) - rnd16(b * s);
                a = rnd16(longint'(v_climb) * dt);
                nz = longint'(alt) + rnd16(longint'(scale) * a);
                if (nz > 0)
                    alt = (nz > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : nz[31:0];
                px = wrap(nx, span_x);
                py = wrap(ny, span_y);
                r.pose_x = px;
                r.pose_y = py;
                r.pose_altitude = alt;
                r.pose_heading = h[19:0];
                r.timed_out = to;
                pending_poses.push_back(r);
            end
            default: ;
        endcase
    endfunction

    // compare one result word with the oldest expected pose
    function void check(ppi_out_t got);
        ppi_out_t exp_w;
        if (pending_poses.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $realtime, got);
            errors++;
            return;
        end
        exp_w = pending_poses.pop_front();
        if (got.pose_x !== exp_w.pose_x)
        begin
            $display("%0t: pose_x exp %h got %h", $realtime, exp_w.pose_x, got.pose_x);
            errors++;
        end
        if (got.pose_y !== exp_w.pose_y)
        begin
            $display("%0t: pose_y exp %h got %h", $realtime, exp_w.pose_y, got.pose_y);
            errors++;
        end
        if (got.pose_altitude !== exp_w.pose_altitude)
        begin
            $display("%0t: pose_altitude exp %h got %h", $realtime,
                     exp_w.pose_altitude, got.pose_altitude);
            errors++;
        end
        if (got.pose_heading !== exp_w.pose_heading)
        begin
            $display("%0t: pose_heading exp %h got %h", $realtime,
                     exp_w.pose_heading, got.pose_heading);
            errors++;
        end
        if (got.timed_out !== exp_w.timed_out)
        begin
            $display("%0t: timed_out exp %b got %b", $realtime,
                     exp_w.timed_out, got.timed_out);
            errors++;
        end
    endfunction
endclass

module testbench;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int SETTLE_CYCLES = 400;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    ppi_in_t   in_data;
    logic      out_valid;
    logic      out_stall;
    ppi_out_t  out_data;
    logic      cfg_write;
    logic [1:0] cfg_index;
    logic [31:0] cfg_data;

    pose_scoreboard sb;
    int        send_idle_pct;
    int        recv_stall_pct;
    int        hold_left;
    int        cycle_count;

    planar_pose_integrator_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // result monitor and receiver stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check(out_data);
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // offer one word and wait for its acceptance
    task automatic send_word(ppi_in_t w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        do
            @(posedge clk);
        while (in_stall);
        sb.note(w);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    task automatic write_all(logic [31:0] sc, logic [31:0] sx, logic [31:0] sy,
                             logic [31:0] tmo);
        write_reg(REG_SCALE, sc);
        write_reg(REG_SPAN_X, sx);
        write_reg(REG_SPAN_Y, sy);
        write_reg(REG_TIMEOUT, tmo);
        cfg_write <= 1'b0;
    endtask

    // wait until every expected pose came back, then let the core settle
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic ppi_in_t make_word(logic [1:0] act);
        ppi_in_t w;
        w.action = act;
        w.linear_speed = 24'($urandom);
        w.turn_rate = 24'($urandom);
        w.climb_speed = 24'($urandom);
        w.new_x = $urandom;
        w.new_y = $urandom;
        w.new_altitude = $urandom;
        w.new_heading = 20'(int'($urandom_range(823548)) - 411774);
        w.step_time = 16'($urandom);
        return w;
    endfunction

    function automatic ppi_in_t random_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 42)
            return make_word(ACT_TICK);
        else if (pick < 77)
            return make_word(ACT_CMD);
        else if (pick < 95)
            return make_word(ACT_TELE);
        else
            return make_word(2'd3);
    endfunction

    task automatic random_phase(int count, int idle_pct, int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count) send_word(random_word());
        drain();
    endtask

    initial
    begin
        ppi_in_t w;
        sb = new();
        cycle_count = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_SCALE;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, every action, special cases
        send_word(make_word(ACT_TICK));
        w = make_word(ACT_CMD);
        w.linear_speed = 24'h7FFFFF;
        w.turn_rate = 24'h7FFFFF;
        w.climb_speed = 24'h7FFFFF;
        send_word(w);
        w = make_word(ACT_TICK);
        w.step_time = 16'hFFFF;
        send_word(w);
        w.step_time = 16'h0000;
        send_word(w);
        // idle timer runs past the limit
        w.step_time = 16'hFFFF;
        send_word(w);
        // teleport to the field extremes, no wrap until a tick
        w = make_word(ACT_TELE);
        w.new_x = 32'hFFFF_FFFF;
        w.new_y = 32'hFFFF_FFFF;
        w.new_altitude = 32'hFFFF_FFFF;
        w.new_heading = 20'sd411774;
        send_word(w);
        w = make_word(ACT_CMD);
        w.linear_speed = 24'h800000;
        w.turn_rate = 24'h800000;
        w.climb_speed = 24'h7FFFFF;
        send_word(w);
        // altitude saturates at all ones
        w = make_word(ACT_TICK);
        w.step_time = 16'h8000;
        send_word(w);
        w = make_word(ACT_TELE);
        w.new_x = 0;
        w.new_y = 0;
        w.new_altitude = 0;
        w.new_heading = -20'sd411774;
        send_word(w);
        w = make_word(ACT_CMD);
        w.climb_speed = 24'h800000;
        w.linear_speed = 24'h800000;
        send_word(w);
        // altitude would go below zero and is kept
        w = make_word(ACT_TICK);
        w.step_time = 16'h4000;
        send_word(w);
        send_word(make_word(2'd3));
        send_word(make_word(ACT_TICK));
        drain();

        // zero spans wrap modulo 2^32, scale at its maximum
        write_all(32'h00FF_FFFF, 32'h0, 32'h0, 32'h0);
        send_word(make_word(ACT_CMD));
        send_word(make_word(ACT_TICK));
        send_word(make_word(ACT_TICK));
        w = make_word(ACT_TELE);
        w.new_heading = 0;
        send_word(w);
        send_word(make_word(ACT_TICK));
        drain();

        write_all(32'h0, 32'h0001_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        random_phase(250, 0, 0);

        write_all(32'h00FF_FFFF, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0);
        random_phase(250, 47, 0);

        write_all(SCALE_RST, SPAN_RST, SPAN_RST, TIMEOUT_RST);
        random_phase(250, 0, 47);

        write_all($urandom_range(24'hFFFFFF), $urandom_range(32'hFFFF_FFFF, 32'h10000),
                  $urandom_range(32'hFFFF_FFFF, 32'h10000), $urandom);
        random_phase(250, 9, 9);

        // long receiver hold while words keep coming, then a full pause
        write_all($urandom_range(24'h3FFFF), $urandom_range(32'h0FFF_FFFF, 32'h10000),
                  $urandom_range(32'h0FFF_FFFF, 32'h10000), $urandom_range(32'h3FFFF));
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 3000;
        repeat (60) send_word(random_word());
        in_valid <= 1'b0;
        while (sb.pending_poses.size() != 0)
            @(posedge clk);
        repeat (150) send_word(random_word());
        drain();

        write_all(32'h0, 32'h0, 32'h0001_0000, $urandom);
        random_phase(260, 47, 47);

        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/ppi_pkg.sv
rtl/core/planar_pose_integrator_core.sv
test/testbench.sv
